FILE: design/tce_pkg.sv
package tce_pkg;

  typedef enum logic [2:0] {
    OP_OPERAND  = 3'd0,
    OP_OPERATOR = 3'd1,
    OP_LCALL    = 3'd2,
    OP_GCALL    = 3'd3,
    OP_RAW      = 3'd4,
    OP_NONE     = 3'd5
  } tce_op_e;

  typedef enum logic {
    REG_LOCAL_COUNT  = 1'b0,
    REG_GLOBAL_COUNT = 1'b1
  } tce_reg_e;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = 3;

  localparam logic [7:0] OpcCallLocal  = 8'd10;
  localparam logic [7:0] OpcCallGlobal = 8'd29;
  localparam logic [7:0] PrefixShort   = 8'd28;
  localparam logic [7:0] PrefixFixed   = 8'd255;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } tce_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } tce_out_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } tce_entry_t;

  // Type2 call bias from the subroutine count
  function automatic logic [15:0] subr_bias(input logic [15:0] count);
    logic [15:0] b;
    if (count < 16'd1240) begin
      b = 16'd107;
    end else if (count < 16'd33900) begin
      b = 16'd1131;
    end else begin
      b = 16'd32768;
    end
    return b;
  endfunction

endpackage

FILE: design/tce_front.sv
module tce_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tce_pkg::tce_in_t   in_data_i,
  input  logic [15:0]        local_count_i,
  input  logic [15:0]        global_count_i,
  output logic               push_o,
  output tce_pkg::tce_entry_t push_data_o,
  input  logic               full_i
);
  import tce_pkg::*;

  logic               a_valid_q, a_valid_d;
  logic [2:0]         a_op_q;
  logic signed [31:0] a_val_q;
  logic signed [31:0] a_val_d;
  logic               a_take;
  logic               a_emits;
  logic               a_drain;

  logic signed [31:0] tp, tn;
  tce_entry_t         ent;
  logic [CntW-1:0]    n;

  // stage A: apply call bias
  always_comb begin
    unique case (in_data_i.op)
      OP_LCALL: a_val_d = in_data_i.value - $signed({16'd0, subr_bias(local_count_i)});
      OP_GCALL: a_val_d = in_data_i.value - $signed({16'd0, subr_bias(global_count_i)});
      default:  a_val_d = in_data_i.value;
    endcase
  end

  always_comb begin
    unique case (a_op_q)
      OP_OPERAND, OP_OPERATOR, OP_LCALL, OP_GCALL, OP_RAW: a_emits = 1'b1;
      default:                                             a_emits = 1'b0;
    endcase
  end

  // items without bytes drain without touching the queue
  assign a_drain    = a_valid_q && (!a_emits || !full_i);
  assign in_ready_o = !a_valid_q || a_drain;
  assign a_take     = in_valid_i && in_ready_o;
  assign a_valid_d  = a_take ? 1'b1 : (a_drain ? 1'b0 : a_valid_q);
  assign push_o     = a_valid_q && a_emits && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      a_op_q  <= in_data_i.op;
      a_val_q <= a_val_d;
    end
  end

  // stage B: classify number and build the byte list
  assign tp = a_val_q - 32'sd108;
  assign tn = -32'sd108 - a_val_q;

  always_comb begin
    ent = '0;
    n   = '0;
    if (a_op_q == OP_OPERATOR || a_op_q == OP_RAW) begin
      ent.bytes[0] = a_val_q[7:0];
      n            = CntW'(1);
    end else begin
      priority if (a_val_q >= -32'sd107 && a_val_q <= 32'sd107) begin
        ent.bytes[0] = 8'(a_val_q[7:0] + 8'd139);
        n            = CntW'(1);
      end else if (a_val_q >= 32'sd108 && a_val_q <= 32'sd1131) begin
        ent.bytes[0] = 8'(8'd247 + {6'd0, tp[9:8]});
        ent.bytes[1] = tp[7:0];
        n            = CntW'(2);
      end else if (a_val_q >= -32'sd1131 && a_val_q <= -32'sd108) begin
        ent.bytes[0] = 8'(8'd251 + {6'd0, tn[9:8]});
        ent.bytes[1] = tn[7:0];
        n            = CntW'(2);
      end else if (a_val_q >= -32'sd32768 && a_val_q <= 32'sd32767) begin
        ent.bytes[0] = PrefixShort;
        ent.bytes[1] = a_val_q[15:8];
        ent.bytes[2] = a_val_q[7:0];
        n            = CntW'(3);
      end else begin
        ent.bytes[0] = PrefixFixed;
        ent.bytes[1] = a_val_q[15:8];
        ent.bytes[2] = a_val_q[7:0];
        n            = CntW'(5);
      end
      if (a_op_q == OP_LCALL) begin
        ent.bytes[n] = OpcCallLocal;
        n            = CntW'(n + CntW'(1));
      end else if (a_op_q == OP_GCALL) begin
        ent.bytes[n] = OpcCallGlobal;
        n            = CntW'(n + CntW'(1));
      end
    end
    ent.count   = n;
    push_data_o = ent;
  end

endmodule

FILE: design/tce_queue.sv
module tce_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tce_pkg::tce_entry_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output tce_pkg::tce_entry_t pop_data_o
);
  import tce_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQ = $clog2(Depth + 1);

  tce_entry_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntQ-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CntQ'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_q + PtrW'(1));
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_q + PtrW'(1));
    end
    if (do_push && !do_pop) begin
      cnt_d = CntQ'(cnt_q + CntQ'(1));
    end else if (do_pop && !do_push) begin
      cnt_d = CntQ'(cnt_q - CntQ'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/tce_back.sv
module tce_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  tce_pkg::tce_entry_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tce_pkg::tce_out_t   out_data_o
);
  import tce_pkg::*;

  tce_entry_t      cur_q;
  logic            cur_valid_q, cur_valid_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            is_last, fire, load;

  assign is_last = (idx_q == CntW'(cur_q.count - CntW'(1)));
  assign fire    = cur_valid_q && out_ready_i;
  // fetch the next entry when empty or on the final byte of the current one
  assign load    = !cur_valid_q || (fire && is_last);
  assign q_pop_o = load && q_valid_i;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      cur_valid_d = q_valid_i;
      idx_d       = '0;
    end else if (fire) begin
      idx_d = CntW'(idx_q + CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  assign out_valid_o         = cur_valid_q;
  assign out_data_o.out_byte = cur_q.bytes[idx_q];
  assign out_data_o.last     = is_last;

endmodule

FILE: design/type2_charstring_encoder_core.sv
// An accepted item is registered in stage A, pushed into the entry queue and then
// loaded into the byte serializer. Throughput: one output byte per cycle while
// out_ready_i is high; a new item is taken every cycle while the entry queue
// between the classifier and the byte serializer has room.
// Reset (rst_ni low, asynchronous) empties the pipeline and queue and clears both
// subroutine counts to zero; no clearing pass follows.
module type2_charstring_encoder_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tce_pkg::tce_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tce_pkg::tce_out_t  out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tce_pkg::*;

  logic [15:0] local_count_q, global_count_q;
  logic        wr_en;
  tce_reg_e    reg_sel;

  logic        push, full, q_valid, q_pop;
  tce_entry_t  push_data, q_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = tce_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_count_q  <= '0;
      global_count_q <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LOCAL_COUNT:  local_count_q  <= pwdata[15:0];
        REG_GLOBAL_COUNT: global_count_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOCAL_COUNT:  prdata = {16'd0, local_count_q};
      REG_GLOBAL_COUNT: prdata = {16'd0, global_count_q};
      default:          prdata = '0;
    endcase
  end

  tce_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .local_count_i  (local_count_q),
    .global_count_i (global_count_q),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (full)
  );

  tce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  tce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
